>>> sv/psf_pkg.sv
// ----------------------------------------------------------------------------
// PNG scanline filter package
// Register indexes, filter codes and field widths shared by the filter RTL.
// ----------------------------------------------------------------------------
package psf_pkg;

  // Field widths fixed by the interface.
  localparam int BYTE_W = 8;
  localparam int FT_W   = 3;
  localparam int PXB_W  = 4;
  localparam int ROW_W  = 14;
  localparam int CFG_AW = 2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_FILTER_TYPE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PIXEL_BYTES = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROW_BYTES   = 2'd2;

  // PNG filter type codes; these are also the tag byte values.
  typedef enum logic [FT_W-1:0] {
    FT_NONE  = 3'd0,
    FT_SUB   = 3'd1,
    FT_UP    = 3'd2,
    FT_AVG   = 3'd3,
    FT_PAETH = 3'd4
  } filter_t;

endpackage

>>> sv/png_scanline_filter.sv
// ----------------------------------------------------------------------------
// PNG scanline filter
// Applies one PNG row filter (none, sub, up, average, Paeth) to raw bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Raw image bytes enter on the in_ stream in raster order, one per transfer;
//   in_tuser marks the first byte of a new image. Each row of row_bytes bytes
//   produces the filter-type tag byte (out_tuser high, out_tlast low) before
//   its first filtered byte; every filtered byte carries out_tlast high.
//   Configuration is written through cfg_we / cfg_addr / cfg_wdata while the
//   block is idle: index 0 filter type, 1 bytes per pixel, 2 row length.
// Timing:
//   A byte is accepted every cycle while the receiver keeps up. Each byte is
//   registered in the prediction stage with the line store read of the up
//   neighbour, then in the output register after the predictor and subtraction.
//   The first byte of a row yields two output transfers, so the output port
//   sets the rate there and the input stalls while the row's tag goes out.
// Reset and stall:
//   Reset clears the configuration to none / 1 / 1 and starts a first row.
//   The line store is not cleared; the first row uses zero for it. When the
//   receiver stalls, results wait in the output register and in_tready drops
//   as soon as the prediction stage is full.
// ----------------------------------------------------------------------------
module png_scanline_filter
  import psf_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] pixel_byte
  input  logic              in_tuser,   // [0] image_start
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_byte
  output logic              out_tuser,  // [0] is_tag
  output logic              out_tlast,  // last result caused by the input byte
  // Configuration write port
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [ROW_W-1:0]  cfg_wdata
);

  localparam int CW    = $clog2(MAX_ROW_BYTES + 1);
  localparam int AW    = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int LW    = (CW > ROW_W) ? CW : ROW_W;
  localparam int PW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int PCW   = (PW + 1 > PXB_W) ? PW + 1 : PXB_W;

  localparam logic [LW-1:0]  ROW_MAX = LW'(MAX_ROW_BYTES);
  localparam logic [PCW-1:0] PIX_MAX = PCW'(MAX_PIXEL_BYTES);

  function automatic logic [9:0] abs10(input logic signed [10:0] v);
    logic signed [10:0] m;
    m = (v < 0) ? -v : v;
    return m[9:0];
  endfunction

  // Configuration registers.
  logic [FT_W-1:0]  filter_type_r;
  logic [PXB_W-1:0] pixel_bytes_r;
  logic [ROW_W-1:0] row_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_type_r <= FT_W'(FT_NONE);
      pixel_bytes_r <= PXB_W'(1);
      row_bytes_r   <= ROW_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FILTER_TYPE: filter_type_r <= cfg_wdata[FT_W-1:0];
        REG_PIXEL_BYTES: pixel_bytes_r <= cfg_wdata[PXB_W-1:0];
        REG_ROW_BYTES:   row_bytes_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamped configuration values.
  logic [LW-1:0]  rb_ext;
  logic [LW-1:0]  rb_eff;
  logic [PCW-1:0] pb_ext;
  logic [PCW-1:0] pb_eff;
  logic [PW-1:0]  pb_idx;
  filter_t        ft_eff;

  always_comb begin
    rb_ext = LW'(row_bytes_r);
    if (rb_ext == '0) begin
      rb_eff = LW'(1);
    end else if (rb_ext > ROW_MAX) begin
      rb_eff = ROW_MAX;
    end else begin
      rb_eff = rb_ext;
    end
    pb_ext = PCW'(pixel_bytes_r);
    if (pb_ext == '0) begin
      pb_eff = PCW'(1);
    end else if (pb_ext > PIX_MAX) begin
      pb_eff = PIX_MAX;
    end else begin
      pb_eff = pb_ext;
    end
    pb_idx = PW'(pb_eff - PCW'(1));
    ft_eff = (filter_type_r <= FT_W'(FT_PAETH)) ? filter_t'(filter_type_r) : FT_NONE;
  end

  // Pipeline handshake: output register, prediction stage, input.
  logic o_valid_r;
  logic o_tag_pend_r;
  logic s1_valid_r;
  logic o_load_ok;
  logic s1_move;
  logic in_xfer;
  logic out_xfer;

  assign out_xfer  = out_tvalid && out_tready;
  assign o_load_ok = !o_valid_r || (out_tready && !o_tag_pend_r);
  assign s1_move   = s1_valid_r && o_load_ok;
  assign in_tready = !s1_valid_r || s1_move;
  assign in_xfer   = in_tvalid && in_tready;

  // Row position tracking at the input.
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic          first_r;
  logic          first_nxt;
  logic [CW-1:0] col_eff;
  logic          fr_eff;
  logic [CW-1:0] col_inc;

  always_comb begin
    if (in_tuser) begin
      col_eff = '0;
      fr_eff  = 1'b1;
    end else if (LW'(col_r) >= rb_eff) begin
      col_eff = '0;
      fr_eff  = 1'b0;
    end else begin
      col_eff = col_r;
      fr_eff  = first_r;
    end
    col_inc = col_eff + CW'(1);
    if (LW'(col_inc) >= rb_eff) begin
      col_nxt   = '0;
      first_nxt = 1'b0;
    end else begin
      col_nxt   = col_inc;
      first_nxt = fr_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
    end else if (in_xfer) begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
    end
  end

  // Line store: read the previous row's byte and write the new one in the
  // same cycle; the read returns the old contents.
  logic [BYTE_W-1:0] line_store [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] up_rd_r;
  logic [AW-1:0]     ls_addr;

  assign ls_addr = col_eff[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      up_rd_r             <= line_store[ls_addr];
      line_store[ls_addr] <= in_tdata;
    end
  end

  // Prediction stage registers.
  logic [BYTE_W-1:0] s1_x_r;
  logic              s1_col0_r;
  logic              s1_first_r;
  logic              s1_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r     <= in_tdata;
      s1_col0_r  <= (col_eff == '0);
      s1_first_r <= fr_eff;
      s1_left_r  <= (PCW'(col_eff) >= pb_eff) || (CW > PCW && (col_eff >> PCW) != '0);
    end
  end

  // Left and upper-left histories, shifted as each byte leaves the stage.
  logic [BYTE_W-1:0] left_hist_r   [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] upleft_hist_r [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] up_b;

  assign up_b = s1_first_r ? '0 : up_rd_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      left_hist_r[0]   <= s1_x_r;
      upleft_hist_r[0] <= up_b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_r[i]   <= left_hist_r[i-1];
        upleft_hist_r[i] <= upleft_hist_r[i-1];
      end
    end
  end

  // Predictor and filtered byte.
  logic [BYTE_W-1:0]  pa;
  logic [BYTE_W-1:0]  pc;
  logic [BYTE_W:0]    avg_sum;
  logic signed [10:0] sa;
  logic signed [10:0] sb;
  logic signed [10:0] sc;
  logic [9:0]         dist_a;
  logic [9:0]         dist_b;
  logic [9:0]         dist_c;
  logic [BYTE_W-1:0]  paeth;
  logic [BYTE_W-1:0]  pred;
  logic [BYTE_W-1:0]  filt;

  always_comb begin
    pa      = s1_left_r ? left_hist_r[pb_idx] : '0;
    pc      = (s1_left_r && !s1_first_r) ? upleft_hist_r[pb_idx] : '0;
    avg_sum = {1'b0, pa} + {1'b0, up_b};
    sa      = signed'({3'b000, pa});
    sb      = signed'({3'b000, up_b});
    sc      = signed'({3'b000, pc});
    dist_a  = abs10(sb - sc);
    dist_b  = abs10(sa - sc);
    dist_c  = abs10(sa + sb - (sc <<< 1));
    if (dist_a <= dist_b && dist_a <= dist_c) begin
      paeth = pa;
    end else if (dist_b <= dist_c) begin
      paeth = up_b;
    end else begin
      paeth = pc;
    end
    unique case (ft_eff)
      FT_SUB:   pred = pa;
      FT_UP:    pred = up_b;
      FT_AVG:   pred = avg_sum[BYTE_W:1];
      FT_PAETH: pred = paeth;
      default:  pred = '0;
    endcase
    filt = s1_x_r - pred;
  end

  // Output register: tag first when the byte opened a row, then the byte.
  logic [BYTE_W-1:0] o_tag_r;
  logic [BYTE_W-1:0] o_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r    <= 1'b0;
      o_tag_pend_r <= 1'b0;
    end else if (s1_move) begin
      o_valid_r    <= 1'b1;
      o_tag_pend_r <= s1_col0_r;
    end else if (out_xfer) begin
      if (o_tag_pend_r) begin
        o_tag_pend_r <= 1'b0;
      end else begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_tag_r  <= BYTE_W'(ft_eff);
      o_byte_r <= filt;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_tag_pend_r ? o_tag_r : o_byte_r;
  assign out_tuser  = o_tag_pend_r;
  assign out_tlast  = !o_tag_pend_r;

endmodule

>>> bench/tb_png_scanline_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline filter testbench
// Streams raw image bytes through the filter under several register settings
// and compares every tag and filtered byte with a behavioral predictor. A short
// scripted sequence covers reset values, field extremes, every filter type,
// the clamped register values and a row shrunk mid-row; random images follow,
// with bursty input, a patterned output stall and long output hold-offs.
// ----------------------------------------------------------------------------
module tb_png_scanline_filter;
  import psf_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 1120;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LINE_DEPTH     = 8192;
  localparam int HIST_DEPTH     = 8;

  // Filter codes above Paeth; the block treats them as filter none.
  localparam logic [FT_W-1:0] FT_UNKNOWN_LO = 3'd5;
  localparam logic [FT_W-1:0] FT_UNKNOWN_HI = 3'd7;

  // One expected output transfer.
  typedef struct packed {
    logic [7:0] data;
    logic       tag;
    logic       last;
  } filt_result_t;

  // One row of the scripted sequence: a register write or a pixel byte.
  typedef enum logic {ST_BYTE, ST_CFG} step_kind_t;
  typedef struct packed {
    step_kind_t        kind;
    logic [CFG_AW-1:0] addr;
    logic [ROW_W-1:0]  value;
    logic              start;
    logic              typed;
    logic [7:0]        want;
  } step_t;

  localparam step_t SCRIPT [0:40] = '{
    // Reset settings: filter none, one byte per row.
    '{ST_BYTE, REG_FILTER_TYPE, 14'h000, 1'b1, 1'b1, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h0FF, 1'b0, 1'b1, 8'hFF},
    // Sub filter, pixel size zero acts as one, four-byte rows.
    '{ST_CFG,  REG_FILTER_TYPE, 14'(FT_SUB), 1'b0, 1'b0, 8'h00},
    '{ST_CFG,  REG_PIXEL_BYTES, 14'd0, 1'b0, 1'b0, 8'h00},
    '{ST_CFG,  REG_ROW_BYTES,   14'd4, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h010, 1'b1, 1'b1, 8'h10},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h005, 1'b0, 1'b1, 8'hF5},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h0FF, 1'b0, 1'b1, 8'hFA},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h000, 1'b0, 1'b1, 8'h01},
    // Up filter on the second row.
    '{ST_CFG,  REG_FILTER_TYPE, 14'(FT_UP), 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h020, 1'b0, 1'b1, 8'h10},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h005, 1'b0, 1'b1, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h000, 1'b0, 1'b1, 8'h01},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h0FF, 1'b0, 1'b1, 8'hFF},
    // Average filter on the third row.
    '{ST_CFG,  REG_FILTER_TYPE, 14'(FT_AVG), 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h080, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h07F, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h0FF, 1'b0, 1'b0, 8'h00},
    // Paeth filter, two bytes per pixel, a fresh image of two 3-byte rows.
    '{ST_CFG,  REG_FILTER_TYPE, 14'(FT_PAETH), 1'b0, 1'b0, 8'h00},
    '{ST_CFG,  REG_PIXEL_BYTES, 14'd2, 1'b0, 1'b0, 8'h00},
    '{ST_CFG,  REG_ROW_BYTES,   14'd3, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h001, 1'b1, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h0FE, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h07F, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h080, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h000, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h0FF, 1'b0, 1'b0, 8'h00},
    // Unknown filter code and all-ones register values, which clamp.
    '{ST_CFG,  REG_FILTER_TYPE, 14'(FT_UNKNOWN_HI), 1'b0, 1'b0, 8'h00},
    '{ST_CFG,  REG_PIXEL_BYTES, 14'd15, 1'b0, 1'b0, 8'h00},
    '{ST_CFG,  REG_ROW_BYTES,   14'h3FFF, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h011, 1'b1, 1'b1, 8'h11},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h022, 1'b0, 1'b1, 8'h22},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h033, 1'b0, 1'b1, 8'h33},
    // Row shrunk below the current column: the next byte opens a new row.
    '{ST_CFG,  REG_FILTER_TYPE, 14'(FT_UNKNOWN_LO), 1'b0, 1'b0, 8'h00},
    '{ST_CFG,  REG_ROW_BYTES,   14'd2, 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h044, 1'b0, 1'b1, 8'h44},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h099, 1'b0, 1'b1, 8'h99},
    // Row length zero acts as one byte per row.
    '{ST_CFG,  REG_ROW_BYTES,   14'd0, 1'b0, 1'b0, 8'h00},
    '{ST_CFG,  REG_FILTER_TYPE, 14'(FT_NONE), 1'b0, 1'b0, 8'h00},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h0AA, 1'b1, 1'b1, 8'hAA},
    '{ST_BYTE, REG_FILTER_TYPE, 14'h055, 1'b0, 1'b1, 8'h55}
  };

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = 8'h00;  // [7:0] pixel_byte
  logic              in_tuser   = 1'b0;   // [0] image_start
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;           // [7:0] out_byte
  logic              out_tuser;           // [0] is_tag
  logic              out_tlast;
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [ROW_W-1:0]  cfg_wdata  = '0;

  // Predictor state: register copies and the filter's own history.
  logic [FT_W-1:0]   cur_filter      = 3'(FT_NONE);
  logic [PXB_W-1:0]  cur_pixel_bytes = 4'd1;
  logic [ROW_W-1:0]  cur_row_bytes   = 14'd1;
  logic [7:0]        prev_row_bytes [LINE_DEPTH];
  bit                row_written    [LINE_DEPTH];
  logic [7:0]        left_bytes     [HIST_DEPTH];
  logic [7:0]        upleft_bytes   [HIST_DEPTH];
  int                row_column   = 0;
  bit                in_first_row = 1'b1;

  filt_result_t      pending_results [$];
  int                result_count  = 0;
  int                error_count   = 0;
  int                stall_cycles  = 0;
  bit                hold_off_req  = 1'b0;

  png_scanline_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Effective row length after clamping to 1..LINE_DEPTH.
  function automatic int eff_row_bytes();
    if (cur_row_bytes == 0) return 1;
    if (cur_row_bytes > LINE_DEPTH) return LINE_DEPTH;
    return int'(cur_row_bytes);
  endfunction

  // True when a byte sent without image start would read an unwritten column.
  function automatic bit reads_unwritten();
    int col;
    bit first;
    col   = row_column;
    first = in_first_row;
    if (col >= eff_row_bytes()) begin
      col   = 0;
      first = 1'b0;
    end
    return !first && !row_written[col];
  endfunction

  // Paeth choice among left, up and upper-left neighbours.
  function automatic int paeth_select(input int a, input int b, input int c);
    int da, db, dc;
    da = (b > c) ? b - c : c - b;
    db = (a > c) ? a - c : c - a;
    dc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Advance the filter state by one accepted byte and queue its results.
  task automatic predict_filtered_byte(input logic [7:0] x, input logic start,
                                       input logic typed, input logic [7:0] want);
    filter_t      ft;
    filt_result_t r;
    int           pxb, rb, a, b, c, pred;
    ft  = (cur_filter <= FT_PAETH) ? filter_t'(cur_filter) : FT_NONE;
    pxb = (cur_pixel_bytes == 0) ? 1 :
          (cur_pixel_bytes > HIST_DEPTH) ? HIST_DEPTH : int'(cur_pixel_bytes);
    rb  = eff_row_bytes();
    if (start) begin
      row_column   = 0;
      in_first_row = 1'b1;
    end else if (row_column >= rb) begin
      row_column   = 0;
      in_first_row = 1'b0;
    end
    // Row start: the tag goes out ahead of the filtered byte.
    if (row_column == 0) begin
      r.data = 8'(ft);
      r.tag  = 1'b1;
      r.last = 1'b0;
      pending_results.push_back(r);
    end
    b = in_first_row ? 0 : int'(prev_row_bytes[row_column]);
    a = (row_column >= pxb) ? int'(left_bytes[pxb-1]) : 0;
    c = (!in_first_row && row_column >= pxb) ? int'(upleft_bytes[pxb-1]) : 0;
    case (ft)
      FT_SUB:   pred = a;
      FT_UP:    pred = b;
      FT_AVG:   pred = (a + b) / 2;
      FT_PAETH: pred = paeth_select(a, b, c);
      default:  pred = 0;
    endcase
    r.data = typed ? want : 8'(int'(x) - pred);
    r.tag  = 1'b0;
    r.last = 1'b1;
    pending_results.push_back(r);
    // Shift the neighbour histories and store the raw byte for the next row.
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      left_bytes[i]   = left_bytes[i-1];
      upleft_bytes[i] = upleft_bytes[i-1];
    end
    left_bytes[0]                = x;
    upleft_bytes[0]              = 8'(b);
    prev_row_bytes[row_column]   = x;
    row_written[row_column]      = 1'b1;
    row_column++;
    if (row_column >= rb) begin
      row_column   = 0;
      in_first_row = 1'b0;
    end
  endtask

  // Offer one byte, hold it until the transfer, then predict its results.
  task automatic push_pixel(input logic [7:0] x, input logic start,
                            input logic typed, input logic [7:0] want);
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    in_tuser  <= start;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_filtered_byte(x, start, typed, want);
  endtask

  task automatic idle_input(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every queued result has arrived.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [ROW_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    case (addr)
      REG_FILTER_TYPE: cur_filter      = value[FT_W-1:0];
      REG_PIXEL_BYTES: cur_pixel_bytes = value[PXB_W-1:0];
      REG_ROW_BYTES:   cur_row_bytes   = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t, result %0d: %s", $realtime, result_count, msg);
    error_count++;
  endtask

  // Compare each output transfer with the oldest queued result.
  always @(posedge clk) begin
    filt_result_t r;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer, byte %h tag %b last %b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        r = pending_results.pop_front();
        if (out_tdata !== r.data)
          report_mismatch($sformatf("byte %h, expected %h", out_tdata, r.data));
        if (out_tuser !== r.tag)
          report_mismatch($sformatf("tag flag %b, expected %b", out_tuser, r.tag));
        if (out_tlast !== r.last)
          report_mismatch($sformatf("last flag %b, expected %b", out_tlast, r.last));
      end
      result_count++;
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: short segments of differing ready patterns, plus a long
  // hold-off whenever the stimulus asks for one.
  initial begin : rx_pattern
    int   span;
    int   style;
    logic ready;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        span  = $urandom_range(4, 40);
        style = $urandom_range(0, 3);
        repeat (span) begin
          case (style)
            0:       ready = 1'b1;
            1:       ready = 1'($urandom_range(0, 1));
            2:       ready = ($urandom_range(0, 3) != 0);
            default: ready = ($urandom_range(0, 3) == 0);
          endcase
          out_tready <= ready;
          @(posedge clk);
        end
      end
    end
  end

  // Stimulus: reset, scripted sequence, then random images.
  initial begin : stimulus
    int          k;
    int          items_sent;
    int          phase_idx;
    int          phase_len;
    int          burst_left;
    int          pick;
    bit          steady;
    logic        start;
    logic [7:0]  x;
    logic [13:0] row_val;

    items_sent = 0;
    phase_idx  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < $size(SCRIPT); k++) begin
      if (SCRIPT[k].kind == ST_CFG) begin
        drain_results();
        write_reg(SCRIPT[k].addr, SCRIPT[k].value);
      end else begin
        push_pixel(SCRIPT[k].value[7:0], SCRIPT[k].start, SCRIPT[k].typed, SCRIPT[k].want);
      end
    end

    while (items_sent < RANDOM_ITEMS) begin
      // New settings only once the block has gone quiet.
      drain_results();
      if (phase_idx == 0 || $urandom_range(0, 3) != 0)
        write_reg(REG_FILTER_TYPE, ($urandom_range(0, 9) == 0) ?
                  14'($urandom_range(FT_UNKNOWN_LO, FT_UNKNOWN_HI)) :
                  14'($urandom_range(FT_NONE, FT_PAETH)));
      if (phase_idx == 0 || $urandom_range(0, 3) != 0)
        write_reg(REG_PIXEL_BYTES, ($urandom_range(0, 9) == 0) ?
                  14'($urandom_range(0, 15)) : 14'($urandom_range(1, HIST_DEPTH)));
      if (phase_idx == 0 || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)       row_val = 14'd0;
        else if (pick < 8)  row_val = 14'($urandom_range(LINE_DEPTH, 16383));
        else if (pick < 18) row_val = 14'($urandom_range(25, 64));
        else                row_val = 14'($urandom_range(1, 24));
        write_reg(REG_ROW_BYTES, row_val);
      end

      phase_len  = $urandom_range(20, 80);
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 48);
      // Long output hold-off while the input keeps coming.
      if (phase_idx == 2 || $urandom_range(0, 9) == 0) begin
        hold_off_req = 1'b1;
        phase_len    = 100;
      end

      for (k = 0; k < phase_len; k++) begin
        // Mostly whole images; a stray image start now and then.
        start = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0);
        start = start | reads_unwritten();
        case ($urandom_range(0, 7))
          0:       x = 8'h00;
          1:       x = 8'hFF;
          default: x = 8'($urandom_range(0, 255));
        endcase
        push_pixel(x, start, 1'b0, 8'h00);
        items_sent++;
        if (!steady) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_input($urandom_range(1, 8));
            burst_left = $urandom_range(1, 48);
          end
        end
        if ($urandom_range(0, 59) == 0)
          drain_results();
      end
      phase_idx++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> png_scanline_filter.f
sv/psf_pkg.sv
sv/png_scanline_filter.sv
bench/tb_png_scanline_filter.sv
